// File: hdl/i2crd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2crd_pkg: shared types and constants of the I2C register read master
// Command codes, register indexes, reset values and the queue entry layout
// used between the command front end and the bus sequencer.
// ----------------------------------------------------------------------------
package i2crd_pkg;

   // command selector on the request side
   localparam logic [1:0] FUNC_TICK = 2'd0;
   localparam logic [1:0] FUNC_RD16 = 2'd1;
   localparam logic [1:0] FUNC_RD24 = 2'd2;

   // configuration register indexes
   localparam logic [1:0] CSR_DEVICE_ADDRESS = 2'd0;
   localparam logic [1:0] CSR_OVERSAMPLING   = 2'd1;
   localparam logic [1:0] CSR_HALF_PERIOD    = 2'd2;
   localparam logic [1:0] CSR_ACK_RETRIES    = 2'd3;

   localparam int CSR_ADDR_W = 2;
   localparam int CSR_DATA_W = 16;

   localparam logic [7:0]  DEVICE_ADDRESS_RST = 8'd238;
   localparam logic [1:0]  OVERSAMPLING_RST   = 2'd3;
   localparam logic [15:0] HALF_PERIOD_RST    = 16'd900;
   localparam logic [7:0]  ACK_RETRIES_RST    = 8'd0;

   localparam int TICK_WIDTH_DEFAULT = 16;

   localparam int REQ_TDATA_W = 16;
   localparam int REQ_TUSER_W = 2;
   localparam int RSP_TDATA_W = 32;

   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_PTR_W = 1;
   localparam int QUEUE_CNT_W = 2;

   // one classified tick as it waits for the sequencer
   typedef struct packed {
      logic       start;
      logic       wide;
      logic [7:0] reg_address;
      logic       sda_in;
   } queue_entry_type;

endpackage

// File: hdl/i2crd_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2crd_front: request intake and command queue
// Unpacks each request transfer, decodes the command selector into start and
// width flags and holds the result in a two-entry queue for the sequencer.
// ----------------------------------------------------------------------------
module i2crd_front (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   // [7:0] reg_address, [8] sda_in, [15:9] zero
   input  logic [i2crd_pkg::REQ_TDATA_W-1:0]     req_tdata,
   // [1:0] func
   input  logic [i2crd_pkg::REQ_TUSER_W-1:0]     req_tuser,
   output logic                                  q_valid,
   output i2crd_pkg::queue_entry_type            q_entry,
   input  logic                                  q_pop
);

   i2crd_pkg::queue_entry_type entry_ff [i2crd_pkg::QUEUE_DEPTH];
   i2crd_pkg::queue_entry_type new_entry;
   logic [i2crd_pkg::QUEUE_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [i2crd_pkg::QUEUE_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [i2crd_pkg::QUEUE_CNT_W-1:0] count_ff, count_in;
   logic push;
   logic pop;

   // selector value 3 falls through as a plain tick
   always_comb begin
      new_entry.start       = req_tuser inside {i2crd_pkg::FUNC_RD16, i2crd_pkg::FUNC_RD24};
      new_entry.wide        = (req_tuser == i2crd_pkg::FUNC_RD24);
      new_entry.reg_address = req_tdata[7:0];
      new_entry.sda_in      = req_tdata[8];
   end

   assign req_tready = (count_ff != i2crd_pkg::QUEUE_CNT_W'(i2crd_pkg::QUEUE_DEPTH));
   assign q_valid    = (count_ff != '0);
   assign q_entry    = entry_ff[rd_ptr_ff];
   assign push       = req_tvalid && req_tready;
   assign pop        = q_pop && q_valid;

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= new_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

// File: hdl/i2crd_seq.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2crd_seq: I2C bus sequencer and response register
// Steps the read transaction by one tick per queued entry, holds the
// configuration registers and drives the response output register.
// ----------------------------------------------------------------------------
module i2crd_seq #(
   parameter int TICK_WIDTH = i2crd_pkg::TICK_WIDTH_DEFAULT
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  csr_we,
   input  logic [i2crd_pkg::CSR_ADDR_W-1:0]      csr_addr,
   input  logic [i2crd_pkg::CSR_DATA_W-1:0]      csr_wdata,
   input  logic                                  q_valid,
   input  i2crd_pkg::queue_entry_type            q_entry,
   output logic                                  q_pop,
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   output logic [i2crd_pkg::RSP_TDATA_W-1:0]     rsp_tdata,
   output logic                                  rsp_tuser
);

   localparam logic [4:0] PH_IDLE  = 5'd0;
   localparam logic [4:0] PH_ST0   = 5'd1;
   localparam logic [4:0] PH_ST1   = 5'd2;
   localparam logic [4:0] PH_ST2   = 5'd3;
   localparam logic [4:0] PH_ST3   = 5'd4;
   localparam logic [4:0] PH_TX_LO = 5'd5;
   localparam logic [4:0] PH_TX_HI = 5'd6;
   localparam logic [4:0] PH_AK_LO = 5'd7;
   localparam logic [4:0] PH_AK_HI = 5'd8;
   localparam logic [4:0] PH_RT_HI = 5'd9;
   localparam logic [4:0] PH_RT_LO = 5'd10;
   localparam logic [4:0] PH_BRK   = 5'd11;
   localparam logic [4:0] PH_RX_LO = 5'd12;
   localparam logic [4:0] PH_RX_HI = 5'd13;
   localparam logic [4:0] PH_AM_LO = 5'd14;
   localparam logic [4:0] PH_AM_HI = 5'd15;
   localparam logic [4:0] PH_N0    = 5'd16;
   localparam logic [4:0] PH_N1    = 5'd17;
   localparam logic [4:0] PH_N2    = 5'd18;
   localparam logic [4:0] PH_N3    = 5'd19;
   localparam logic [4:0] PH_N4    = 5'd20;
   localparam logic [4:0] PH_N5    = 5'd21;

   localparam int HP_W = 16;
   localparam int CMP_W = ((TICK_WIDTH > HP_W) ? TICK_WIDTH : HP_W) + 1;

   // SCL level and SDA pull-low for each phase; TX phases take SDA from the data
   function automatic logic [1:0] pin_levels(input logic [4:0] ph);
      logic [1:0] lv;
      case (ph)
         PH_IDLE:  lv = 2'b01;
         PH_ST0:   lv = 2'b01;
         PH_ST1:   lv = 2'b01;
         PH_ST2:   lv = 2'b11;
         PH_ST3:   lv = 2'b10;
         PH_TX_LO: lv = 2'b00;
         PH_TX_HI: lv = 2'b01;
         PH_AK_LO: lv = 2'b00;
         PH_AK_HI: lv = 2'b01;
         PH_RT_HI: lv = 2'b01;
         PH_RT_LO: lv = 2'b00;
         PH_BRK:   lv = 2'b00;
         PH_RX_LO: lv = 2'b00;
         PH_RX_HI: lv = 2'b01;
         PH_AM_LO: lv = 2'b10;
         PH_AM_HI: lv = 2'b11;
         PH_N0:    lv = 2'b00;
         PH_N1:    lv = 2'b00;
         PH_N2:    lv = 2'b01;
         PH_N3:    lv = 2'b00;
         PH_N4:    lv = 2'b10;
         PH_N5:    lv = 2'b11;
         default:  lv = 2'b01;
      endcase
      return lv;
   endfunction

   logic [7:0]            device_address_ff;
   logic [1:0]            oversampling_ff;
   logic [HP_W-1:0]       half_period_ff;
   logic [7:0]            ack_retries_ff;

   logic [4:0]            phase_ff, phase_in;
   logic [TICK_WIDTH-1:0] tick_ff, tick_in;
   logic [2:0]            bit_ff, bit_in;
   logic [1:0]            byte_ff, byte_in;
   logic [23:0]           shift_ff, shift_in;
   logic [7:0]            retry_ff, retry_in;
   logic                  wide_ff, wide_in;
   logic [7:0]            reg_ff, reg_in;
   logic                  error_ff, error_in;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic [i2crd_pkg::RSP_TDATA_W-1:0] rsp_data_ff, rsp_data_in;
   logic                  rsp_done_ff, rsp_done_in;

   logic                  take;
   logic                  phase_end;
   logic                  ack_done;
   logic                  done;
   logic [23:0]           result;
   logic [CMP_W-1:0]      tick_next;
   logic [7:0]            tx_byte;
   logic [1:0]            levels;
   logic                  sda_low;
   logic [3:0]            rshift;

   assign take  = q_valid && (!rsp_valid_ff || rsp_tready);
   assign q_pop = take;

   assign tick_next = CMP_W'(tick_ff) + 1'b1;
   assign phase_end = (tick_next >= CMP_W'(half_period_ff)) || (&tick_ff);
   assign rshift    = 4'd8 - {2'b00, oversampling_ff};

   always_comb begin
      phase_in = phase_ff;
      tick_in  = tick_ff;
      bit_in   = bit_ff;
      byte_in  = byte_ff;
      shift_in = shift_ff;
      retry_in = retry_ff;
      wide_in  = wide_ff;
      reg_in   = reg_ff;
      error_in = error_ff;
      ack_done = 1'b0;
      done     = 1'b0;
      result   = '0;

      if (phase_ff == PH_IDLE) begin
         if (q_entry.start) begin
            reg_in   = q_entry.reg_address;
            wide_in  = q_entry.wide;
            error_in = 1'b0;
            shift_in = '0;
            byte_in  = '0;
            bit_in   = 3'd7;
            retry_in = '0;
            tick_in  = '0;
            phase_in = PH_ST0;
         end
      end else if (phase_end) begin
         tick_in = '0;
         case (phase_ff)
            PH_ST0: phase_in = PH_ST1;
            PH_ST1: phase_in = PH_ST2;
            PH_ST2: phase_in = PH_ST3;
            PH_ST3: begin
               bit_in   = 3'd7;
               phase_in = PH_TX_LO;
            end
            PH_TX_LO: phase_in = PH_TX_HI;
            PH_TX_HI: begin
               if (bit_ff == 3'd0) begin
                  retry_in = '0;
                  phase_in = PH_AK_LO;
               end else begin
                  bit_in   = bit_ff - 1'b1;
                  phase_in = PH_TX_LO;
               end
            end
            PH_AK_LO: phase_in = PH_AK_HI;
            PH_AK_HI: begin
               if (!q_entry.sda_in) begin
                  ack_done = 1'b1;
               end else if (retry_ff < ack_retries_ff) begin
                  phase_in = PH_RT_HI;
               end else begin
                  error_in = 1'b1;
                  ack_done = 1'b1;
               end
            end
            PH_RT_HI: begin
               if (!q_entry.sda_in) begin
                  ack_done = 1'b1;
               end else begin
                  retry_in = retry_ff + 1'b1;
                  phase_in = PH_RT_LO;
               end
            end
            PH_RT_LO: begin
               if (retry_ff < ack_retries_ff) begin
                  phase_in = PH_RT_HI;
               end else begin
                  error_in = 1'b1;
                  ack_done = 1'b1;
               end
            end
            PH_BRK:   phase_in = PH_ST0;
            PH_RX_LO: phase_in = PH_RX_HI;
            PH_RX_HI: begin
               shift_in = {shift_ff[22:0], q_entry.sda_in};
               if (bit_ff == 3'd0) begin
                  bit_in   = 3'd7;
                  byte_in  = byte_ff + 1'b1;
                  phase_in = (byte_in >= (wide_ff ? 2'd3 : 2'd2)) ? PH_N0 : PH_AM_LO;
               end else begin
                  bit_in   = bit_ff - 1'b1;
                  phase_in = PH_RX_LO;
               end
            end
            PH_AM_LO: phase_in = PH_AM_HI;
            PH_AM_HI: phase_in = PH_RX_LO;
            PH_N0:    phase_in = PH_N1;
            PH_N1:    phase_in = PH_N2;
            PH_N2:    phase_in = PH_N3;
            PH_N3:    phase_in = PH_N4;
            PH_N4:    phase_in = PH_N5;
            PH_N5: begin
               done     = 1'b1;
               result   = wide_ff ? (shift_ff >> rshift) : {8'h00, shift_ff[15:0]};
               phase_in = PH_IDLE;
            end
            default: phase_in = PH_IDLE;
         endcase

         // leave the acknowledge check for whatever follows this byte
         if (ack_done) begin
            bit_in = 3'd7;
            case (byte_ff)
               2'd0: begin
                  byte_in  = 2'd1;
                  phase_in = PH_TX_LO;
               end
               2'd1: begin
                  byte_in  = 2'd2;
                  phase_in = PH_BRK;
               end
               default: begin
                  byte_in  = 2'd0;
                  phase_in = PH_RX_LO;
               end
            endcase
         end
      end else begin
         tick_in = tick_ff + 1'b1;
      end
   end

   // drive the pins for the phase being entered
   always_comb begin
      case (byte_in)
         2'd0:    tx_byte = device_address_ff;
         2'd1:    tx_byte = reg_in;
         default: tx_byte = device_address_ff + 1'b1;
      endcase
      levels = pin_levels(phase_in);
      if (phase_in == PH_TX_LO || phase_in == PH_TX_HI) begin
         sda_low = !tx_byte[bit_in];
      end else begin
         sda_low = levels[1];
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_done_in  = rsp_done_ff;
      if (take) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = {4'b0000, error_in, result,
                         (phase_in != PH_IDLE), sda_low, levels[0]};
         rsp_done_in  = done;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         device_address_ff <= i2crd_pkg::DEVICE_ADDRESS_RST;
         oversampling_ff   <= i2crd_pkg::OVERSAMPLING_RST;
         half_period_ff    <= i2crd_pkg::HALF_PERIOD_RST;
         ack_retries_ff    <= i2crd_pkg::ACK_RETRIES_RST;
      end else if (csr_we) begin
         case (csr_addr)
            i2crd_pkg::CSR_DEVICE_ADDRESS: device_address_ff <= csr_wdata[7:0];
            i2crd_pkg::CSR_OVERSAMPLING:   oversampling_ff   <= csr_wdata[1:0];
            i2crd_pkg::CSR_HALF_PERIOD:    half_period_ff    <= csr_wdata[HP_W-1:0];
            i2crd_pkg::CSR_ACK_RETRIES:    ack_retries_ff    <= csr_wdata[7:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_IDLE;
         tick_ff      <= '0;
         bit_ff       <= 3'd7;
         byte_ff      <= '0;
         shift_ff     <= '0;
         retry_ff     <= '0;
         wide_ff      <= 1'b0;
         reg_ff       <= '0;
         error_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (take) begin
            phase_ff <= phase_in;
            tick_ff  <= tick_in;
            bit_ff   <= bit_in;
            byte_ff  <= byte_in;
            shift_ff <= shift_in;
            retry_ff <= retry_in;
            wide_ff  <= wide_in;
            reg_ff   <= reg_in;
            error_ff <= error_in;
         end
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
      rsp_done_ff <= rsp_done_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_done_ff;

   a_done_ends_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_done_ff |-> !rsp_data_ff[2])
      else $error("done response still shows the bus busy");

   a_start_enters_st0: assert property (@(posedge clock) disable iff (reset)
      take && (phase_ff == PH_IDLE) && q_entry.start |=> (phase_ff == PH_ST0))
      else $error("read command did not open a start sequence");

   a_idle_counter_clear: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_IDLE) |-> (tick_ff == '0))
      else $error("phase counter running while idle");

   a_error_from_ack: assert property (@(posedge clock) disable iff (reset)
      $rose(error_ff) |-> ($past(phase_ff) == PH_AK_HI || $past(phase_ff) == PH_RT_LO))
      else $error("acknowledge error raised outside an acknowledge check");

endmodule

// File: hdl/i2c_register_read_master.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2c_register_read_master: bit-level I2C master for one register read
// Each request transfer is one bus tick carrying a command, a register address
// and the sampled SDA level; each tick yields one response transfer with the
// SCL and SDA drive levels, busy and done flags, the read value and the
// acknowledge error flag.
// ----------------------------------------------------------------------------
// The block takes one request per clock cycle when the response side does not stall
// it, and returns exactly one response per request, in order. A request passes a
// two-entry command queue and the sequencer step, which registers the response.
// The sequencer step, one bus tick per cycle, sets the sustained rate of one
// request a cycle while the response side is not stalled. Configuration writes
// are taken at any cycle and are meant for when no read is running.

module i2c_register_read_master #(
   parameter int TICK_WIDTH = i2crd_pkg::TICK_WIDTH_DEFAULT
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  csr_we,
   input  logic [i2crd_pkg::CSR_ADDR_W-1:0]      csr_addr,
   input  logic [i2crd_pkg::CSR_DATA_W-1:0]      csr_wdata,
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   // [7:0] reg_address, [8] sda_in, [15:9] zero
   input  logic [i2crd_pkg::REQ_TDATA_W-1:0]     req_tdata,
   // [1:0] func
   input  logic [i2crd_pkg::REQ_TUSER_W-1:0]     req_tuser,
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   // [0] scl, [1] sda_low, [2] busy_res, [26:3] read_data, [27] ack_error,
   // [31:28] zero
   output logic [i2crd_pkg::RSP_TDATA_W-1:0]     rsp_tdata,
   // [0] done_res
   output logic                                  rsp_tuser
);

   logic                       q_valid;
   logic                       q_pop;
   i2crd_pkg::queue_entry_type q_entry;

   i2crd_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .q_valid    (q_valid),
      .q_entry    (q_entry),
      .q_pop      (q_pop)
   );

   i2crd_seq #(
      .TICK_WIDTH (TICK_WIDTH)
   ) u_seq (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata),
      .q_valid    (q_valid),
      .q_entry    (q_entry),
      .q_pop      (q_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

// File: test/tb_i2c_register_read_master.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_i2c_register_read_master: self-checking bench for the I2C register reader
// Drives bus ticks with commands, register addresses and SDA levels into the
// request stream, keeps its own cycle-true copy of the bus sequencer and
// compares every response transfer field by field against it, under random
// stalls on both streams and across several register settings.
// ----------------------------------------------------------------------------
module tb_i2c_register_read_master;

   localparam logic [1:0] FUNC_SPARE = 2'd3;  // unused selector, acts as a plain tick
   localparam int         TICK_MAX   = (1 << i2crd_pkg::TICK_WIDTH_DEFAULT) - 1;
   localparam int         RANDOM_ITEMS = 800;

   typedef enum logic [4:0] {
      S_IDLE, S_START0, S_START1, S_START2, S_START3, S_TX_LOW, S_TX_HIGH,
      S_ACK_LOW, S_ACK_HIGH, S_RETRY_HIGH, S_RETRY_LOW, S_RESTART_GAP,
      S_RX_LOW, S_RX_HIGH, S_MACK_LOW, S_MACK_HIGH,
      S_STOP0, S_STOP1, S_STOP2, S_STOP3, S_STOP4, S_STOP5
   } bus_phase_type;

   typedef enum logic [1:0] {ACK_ALWAYS, ACK_NEVER, ACK_RANDOM} ack_mode_type;

   typedef struct packed {
      logic        scl;
      logic        sda_low;
      logic        busy;
      logic        done;
      logic [23:0] read_data;
      logic        ack_error;
   } bus_tick_type;

   logic                              clock;
   logic                              reset;
   logic                              csr_we;
   logic [i2crd_pkg::CSR_ADDR_W-1:0]  csr_addr;
   logic [i2crd_pkg::CSR_DATA_W-1:0]  csr_wdata;
   logic                              req_tvalid;
   logic                              req_tready;
   // [7:0] reg_address, [8] sda_in, [15:9] zero
   logic [i2crd_pkg::REQ_TDATA_W-1:0] req_tdata;
   logic [i2crd_pkg::REQ_TUSER_W-1:0] req_tuser;   // [1:0] func
   logic                              rsp_tvalid;
   logic                              rsp_tready;
   // [0] scl, [1] sda_low, [2] busy_res, [26:3] read_data, [27] ack_error,
   // [31:28] zero
   logic [i2crd_pkg::RSP_TDATA_W-1:0] rsp_tdata;
   logic                              rsp_tuser;   // [0] done_res

   // model of the sequencer: configuration and state
   logic [7:0]    cfg_device;
   logic [1:0]    cfg_oversampling;
   logic [15:0]   cfg_half_period;
   logic [7:0]    cfg_retries;
   bus_phase_type bus_phase;
   int unsigned   tick_cnt;
   logic [2:0]    bit_idx;
   logic [1:0]    byte_idx;
   logic [23:0]   shift_reg;
   logic [7:0]    retry_cnt;
   logic          wide_read;
   logic [7:0]    latched_reg;
   logic          nack_seen;

   bus_tick_type  expected_bus_ticks[$];
   bus_tick_type  head_tick;
   int            mismatch_count;
   int            ticks_sent;
   int            send_idle_pct;
   int            recv_idle_pct;

   i2c_register_read_master DUT (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always begin
      clock = 1'b1;
      #4;
      clock = 1'b0;
      #4;
   end

   // {sda pull-low, scl} held by each phase; transmit phases take SDA from the data bit
   function automatic logic [1:0] pin_levels(bus_phase_type p);
      case (p)
         S_START2, S_MACK_HIGH, S_STOP5:                          return 2'b11;
         S_START3, S_MACK_LOW, S_STOP4:                           return 2'b10;
         S_IDLE, S_START0, S_START1, S_TX_HIGH, S_ACK_HIGH,
         S_RETRY_HIGH, S_RX_HIGH, S_STOP2:                        return 2'b01;
         default:                                                 return 2'b00;
      endcase
   endfunction

   function automatic logic [7:0] address_byte();
      case (byte_idx)
         2'd0:    return cfg_device;
         2'd1:    return latched_reg;
         default: return cfg_device + 8'd1;
      endcase
   endfunction

   function automatic void leave_ack();
      bit_idx = 3'd7;
      case (byte_idx)
         2'd0: begin
            byte_idx  = 2'd1;
            bus_phase = S_TX_LOW;
         end
         2'd1: begin
            byte_idx  = 2'd2;
            bus_phase = S_RESTART_GAP;
         end
         default: begin
            byte_idx  = 2'd0;
            bus_phase = S_RX_LOW;
         end
      endcase
   endfunction

   function automatic void fail_ack();
      nack_seen = 1'b1;
      leave_ack();
   endfunction

   // advance the sequencer copy by one bus tick and return the response it yields
   function automatic bus_tick_type step_bus_master(logic [1:0] func, logic [7:0] reg_addr,
                                                    logic sda);
      bus_tick_type r;
      logic [1:0]   pins;
      logic [7:0]   tx;
      r = '0;
      if (bus_phase == S_IDLE) begin
         if (func == i2crd_pkg::FUNC_RD16 || func == i2crd_pkg::FUNC_RD24) begin
            latched_reg = reg_addr;
            wide_read   = (func == i2crd_pkg::FUNC_RD24);
            nack_seen   = 1'b0;
            shift_reg   = '0;
            byte_idx    = 2'd0;
            bit_idx     = 3'd7;
            retry_cnt   = '0;
            tick_cnt    = 0;
            bus_phase   = S_START0;
         end
      end else if (tick_cnt + 1 >= cfg_half_period || tick_cnt >= TICK_MAX) begin
         tick_cnt = 0;
         case (bus_phase)
            S_START0: bus_phase = S_START1;
            S_START1: bus_phase = S_START2;
            S_START2: bus_phase = S_START3;
            S_START3: begin
               bit_idx   = 3'd7;
               bus_phase = S_TX_LOW;
            end
            S_TX_LOW: bus_phase = S_TX_HIGH;
            S_TX_HIGH: begin
               if (bit_idx == 3'd0) begin
                  retry_cnt = '0;
                  bus_phase = S_ACK_LOW;
               end else begin
                  bit_idx   = bit_idx - 3'd1;
                  bus_phase = S_TX_LOW;
               end
            end
            S_ACK_LOW: bus_phase = S_ACK_HIGH;
            S_ACK_HIGH: begin
               if (!sda) leave_ack();
               else if (retry_cnt < cfg_retries) bus_phase = S_RETRY_HIGH;
               else fail_ack();
            end
            S_RETRY_HIGH: begin
               if (!sda) begin
                  leave_ack();
               end else begin
                  retry_cnt = retry_cnt + 8'd1;
                  bus_phase = S_RETRY_LOW;
               end
            end
            S_RETRY_LOW: begin
               if (retry_cnt < cfg_retries) bus_phase = S_RETRY_HIGH;
               else fail_ack();
            end
            S_RESTART_GAP: bus_phase = S_START0;
            S_RX_LOW: bus_phase = S_RX_HIGH;
            S_RX_HIGH: begin
               shift_reg = {shift_reg[22:0], sda};
               if (bit_idx == 3'd0) begin
                  bit_idx   = 3'd7;
                  byte_idx  = byte_idx + 2'd1;
                  bus_phase = (byte_idx >= (wide_read ? 2'd3 : 2'd2)) ? S_STOP0 : S_MACK_LOW;
               end else begin
                  bit_idx   = bit_idx - 3'd1;
                  bus_phase = S_RX_LOW;
               end
            end
            S_MACK_LOW:  bus_phase = S_MACK_HIGH;
            S_MACK_HIGH: bus_phase = S_RX_LOW;
            S_STOP0:     bus_phase = S_STOP1;
            S_STOP1:     bus_phase = S_STOP2;
            S_STOP2:     bus_phase = S_STOP3;
            S_STOP3:     bus_phase = S_STOP4;
            S_STOP4:     bus_phase = S_STOP5;
            S_STOP5: begin
               r.done = 1'b1;
               if (wide_read) r.read_data = shift_reg >> (4'd8 - cfg_oversampling);
               else r.read_data = {8'd0, shift_reg[15:0]};
               bus_phase = S_IDLE;
            end
            default: bus_phase = S_IDLE;
         endcase
      end else begin
         tick_cnt = tick_cnt + 1;
      end
      pins    = pin_levels(bus_phase);
      r.scl   = pins[0];
      tx      = address_byte();
      if (bus_phase == S_TX_LOW || bus_phase == S_TX_HIGH)
         r.sda_low = ~tx[bit_idx];
      else
         r.sda_low = pins[1];
      r.busy      = (bus_phase != S_IDLE);
      r.ack_error = nack_seen;
      return r;
   endfunction

   task automatic report_mismatch(string what, longint got, longint want);
      mismatch_count++;
      if (mismatch_count <= 60)
         $display("MISMATCH %s at %0t ns: got %0h, want %0h", what, $time, got, want);
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_bus_ticks.size() == 0) begin
            report_mismatch("response with nothing outstanding", rsp_tdata, 0);
         end else begin
            head_tick = expected_bus_ticks.pop_front();
            if (rsp_tdata[0] !== head_tick.scl)
               report_mismatch("scl", rsp_tdata[0], head_tick.scl);
            if (rsp_tdata[1] !== head_tick.sda_low)
               report_mismatch("sda_low", rsp_tdata[1], head_tick.sda_low);
            if (rsp_tdata[2] !== head_tick.busy)
               report_mismatch("busy_res", rsp_tdata[2], head_tick.busy);
            if (rsp_tdata[26:3] !== head_tick.read_data)
               report_mismatch("read_data", rsp_tdata[26:3], head_tick.read_data);
            if (rsp_tdata[27] !== head_tick.ack_error)
               report_mismatch("ack_error", rsp_tdata[27], head_tick.ack_error);
            if (rsp_tuser !== head_tick.done)
               report_mismatch("done_res", rsp_tuser, head_tick.done);
         end
      end
   end

   always @(negedge clock)
      rsp_tready <= ($urandom_range(99) >= recv_idle_pct);

   task automatic set_idling(int send_pct, int recv_pct);
      send_idle_pct = send_pct;
      recv_idle_pct = recv_pct;
   endtask

   // one bus tick over the request stream; the model steps on the transfer
   task automatic send_tick(logic [1:0] func, logic [7:0] reg_addr, logic sda);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= func;
      req_tdata  <= {7'd0, sda, reg_addr};
      do @(posedge clock); while (!req_tready);
      expected_bus_ticks.push_back(step_bus_master(func, reg_addr, sda));
      ticks_sent++;
      @(negedge clock);
   endtask

   // SDA as a device would answer: acknowledge levels on the sampling phases
   function automatic logic pick_sda(ack_mode_type mode);
      if (bus_phase == S_ACK_HIGH || bus_phase == S_RETRY_HIGH) begin
         case (mode)
            ACK_ALWAYS: return 1'b0;
            ACK_NEVER:  return 1'b1;
            default:    return ($urandom_range(99) >= 75);
         endcase
      end
      return 1'($urandom_range(1));
   endfunction

   // start a read and keep ticking until the bus is idle again or the cap is hit;
   // the busy ticks carry random commands, which must be ignored
   task automatic run_read(logic [1:0] func, logic [7:0] reg_addr, ack_mode_type mode,
                           int max_ticks);
      int n;
      n = 0;
      send_tick(func, reg_addr, pick_sda(mode));
      while (bus_phase != S_IDLE && n < max_ticks) begin
         send_tick(2'($urandom_range(3)), 8'($urandom_range(255)), pick_sda(mode));
         n++;
      end
   endtask

   task automatic idle_ticks(int count);
      repeat (count)
         send_tick($urandom_range(1) ? FUNC_SPARE : i2crd_pkg::FUNC_TICK,
                   8'($urandom_range(255)), 1'($urandom_range(1)));
   endtask

   // hold the request stream until every outstanding response has arrived
   task automatic drain();
      req_tvalid <= 1'b0;
      while (expected_bus_ticks.size() != 0) @(posedge clock);
      @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_csr(logic [i2crd_pkg::CSR_ADDR_W-1:0] idx,
                            logic [i2crd_pkg::CSR_DATA_W-1:0] value);
      csr_we    <= 1'b1;
      csr_addr  <= idx;
      csr_wdata <= value;
      @(negedge clock);
      csr_we    <= 1'b0;
      @(negedge clock);
      case (idx)
         i2crd_pkg::CSR_DEVICE_ADDRESS: cfg_device       = value[7:0];
         i2crd_pkg::CSR_OVERSAMPLING:   cfg_oversampling = value[1:0];
         i2crd_pkg::CSR_HALF_PERIOD:    cfg_half_period  = value;
         i2crd_pkg::CSR_ACK_RETRIES:    cfg_retries      = value[7:0];
         default: ;
      endcase
   endtask

   task automatic configure(logic [7:0] device, logic [1:0] oversampling,
                            logic [15:0] half_period, logic [7:0] retries);
      drain();
      write_csr(i2crd_pkg::CSR_DEVICE_ADDRESS, {8'd0, device});
      write_csr(i2crd_pkg::CSR_OVERSAMPLING, {14'd0, oversampling});
      write_csr(i2crd_pkg::CSR_HALF_PERIOD, half_period);
      write_csr(i2crd_pkg::CSR_ACK_RETRIES, {8'd0, retries});
   endtask

   task automatic test_idle_ticks();
      send_tick(i2crd_pkg::FUNC_TICK, 8'h00, 1'b0);
      send_tick(i2crd_pkg::FUNC_TICK, 8'hFF, 1'b1);
      send_tick(FUNC_SPARE, 8'hA5, 1'b0);
      send_tick(FUNC_SPARE, 8'h5A, 1'b1);
   endtask

   task automatic test_read16_acked();
      configure(8'd0, 2'd0, 16'd1, 8'd0);
      run_read(i2crd_pkg::FUNC_RD16, 8'h00, ACK_ALWAYS, 100000);
   endtask

   // no acknowledge anywhere; zero half period counts as one tick
   task automatic test_read24_unacked();
      configure(8'd254, 2'd3, 16'd0, 8'd0);
      run_read(i2crd_pkg::FUNC_RD24, 8'hFF, ACK_NEVER, 100000);
      idle_ticks(2);
   endtask

   task automatic test_ack_retries();
      configure(8'h55, 2'd1, 16'd2, 8'd4);
      run_read(i2crd_pkg::FUNC_RD24, 8'hC3, ACK_NEVER, 100000);
      configure(8'hAA, 2'd2, 16'd1, 8'd255);
      run_read(i2crd_pkg::FUNC_RD16, 8'h3C, ACK_RANDOM, 100000);
   endtask

   task automatic test_random_reads();
      int           start_count;
      int           sel;
      ack_mode_type mode;
      start_count = ticks_sent;
      while (ticks_sent - start_count < RANDOM_ITEMS) begin
         if (ticks_sent - start_count < RANDOM_ITEMS / 3) set_idling(31, 57);
         else if (ticks_sent - start_count < 2 * RANDOM_ITEMS / 3) set_idling(57, 31);
         else set_idling(0, 0);
         if ($urandom_range(1)) begin
            sel = $urandom_range(99);
            configure(8'($urandom_range(254)), 2'($urandom_range(3)),
                      ($urandom_range(99) < 70) ? 16'd1 : 16'($urandom_range(6)),
                      (sel < 60) ? 8'd0 : (sel < 92) ? 8'($urandom_range(1, 3)) : 8'd255);
         end
         idle_ticks($urandom_range(3));
         sel  = $urandom_range(99);
         mode = (sel < 10) ? ACK_ALWAYS : (sel < 20) ? ACK_NEVER : ACK_RANDOM;
         run_read($urandom_range(1) ? i2crd_pkg::FUNC_RD24 : i2crd_pkg::FUNC_RD16,
                  8'($urandom_range(255)), mode, 100000);
      end
   endtask

   // longest phase setting: only the opening of a read fits in the run
   task automatic test_longest_phase();
      configure(8'($urandom_range(254)), 2'($urandom_range(3)), 16'hFFFF, 8'd0);
      run_read(i2crd_pkg::FUNC_RD16, 8'($urandom_range(255)), ACK_RANDOM, 100);
   endtask

   initial begin
      int waited;
      reset          = 1'b1;
      csr_we         = 1'b0;
      csr_addr       = '0;
      csr_wdata      = '0;
      req_tvalid     = 1'b0;
      req_tdata      = '0;
      req_tuser      = i2crd_pkg::FUNC_TICK;
      rsp_tready     = 1'b0;
      mismatch_count = 0;
      ticks_sent     = 0;
      cfg_device       = i2crd_pkg::DEVICE_ADDRESS_RST;
      cfg_oversampling = i2crd_pkg::OVERSAMPLING_RST;
      cfg_half_period  = i2crd_pkg::HALF_PERIOD_RST;
      cfg_retries      = i2crd_pkg::ACK_RETRIES_RST;
      bus_phase   = S_IDLE;
      tick_cnt    = 0;
      bit_idx     = 3'd7;
      byte_idx    = 2'd0;
      shift_reg   = '0;
      retry_cnt   = '0;
      wide_read   = 1'b0;
      latched_reg = '0;
      nack_seen   = 1'b0;
      set_idling(31, 57);
      repeat (5) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      test_idle_ticks();
      test_read16_acked();
      test_read24_unacked();
      test_ack_retries();
      test_random_reads();
      set_idling(0, 0);
      test_longest_phase();

      req_tvalid <= 1'b0;
      waited = 0;
      while (expected_bus_ticks.size() != 0 && waited < 100000) begin
         @(posedge clock);
         waited++;
      end
      repeat (20) @(posedge clock);
      if (expected_bus_ticks.size() != 0)
         report_mismatch("responses never returned", 0, expected_bus_ticks.size());
      if (mismatch_count == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

   initial begin
      #4_000_000;
      $display("tb: failure");
      $finish;
   end

endmodule
